// ===== sv/gsle_pkg.sv =====
// Package for the GBK sentence label extractor.
// Holds the transaction types, the phase enum, byte constants and helper functions.
// No dependencies.
package gsle_pkg;

  localparam int unsigned FifoDepth  = 8;
  localparam int unsigned FifoPtrW   = $clog2(FifoDepth);
  localparam int unsigned FifoCntW   = $clog2(FifoDepth + 1);
  localparam int unsigned MaxResults = 3;
  localparam int unsigned ApbAddrW   = 3;

  localparam logic [ApbAddrW-1:0] RegMaxLabelBytes = 3'd0;
  localparam logic [7:0]          MaxLabelReset    = 8'd32;

  localparam logic [7:0] ChrCr     = 8'h0D;
  localparam logic [7:0] ChrLf     = 8'h0A;
  localparam logic [7:0] ChrSpace  = 8'h20;
  localparam logic [7:0] ChrTab    = 8'h09;
  localparam logic [7:0] ChrA1     = 8'hA1;
  localparam logic [7:0] LeadMin   = 8'h81;
  localparam logic [7:0] TrailMin  = 8'h40;
  localparam logic [7:0] PunctA3   = 8'hA3;
  localparam logic [7:0] PunctBf   = 8'hBF;
  localparam logic [7:0] PunctB6   = 8'hB6;
  localparam logic [7:0] PunctAd   = 8'hAD;

  typedef enum logic [1:0] {
    PhSkip = 2'd0,
    PhCopy = 2'd1,
    PhDone = 2'd2
  } gsle_phase_e;

  typedef struct packed {
    logic [7:0] in_byte;
    logic       chunk_end;
  } gsle_in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       label_end;
    logic [7:0] label_length;
  } gsle_out_t;

  // Results of one input transaction, handed from the core to the result queue.
  typedef struct packed {
    logic [1:0]                     count;
    gsle_out_t [MaxResults-1:0]     item;
  } gsle_push_t;

  function automatic logic has_room(logic [7:0] wc, logic [7:0] max_bytes);
    return ({1'b0, wc} + 9'd3) < {1'b0, max_bytes};
  endfunction

  function automatic logic is_end_punct(logic [7:0] lead, logic [7:0] trail);
    return (lead == ChrA1) &&
           ((trail == PunctA3) || (trail == PunctBf) ||
            (trail == PunctB6) || (trail == PunctAd));
  endfunction

endpackage

// ===== sv/gsle_core.sv =====
// Extraction core: input register, scan state and the single-pass result logic.
// Depends on gsle_pkg.
module gsle_core import gsle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  gsle_in_t   in_data_i,
  input  logic [7:0] max_bytes_i,
  input  logic       room_i,
  output gsle_push_t push_o
);

  logic          in_valid_q, in_valid_d;
  gsle_in_t      in_q;
  gsle_phase_e   phase_q, phase_d;
  logic [7:0]    held_q, held_d;
  logic          held_valid_q, held_valid_d;
  logic [7:0]    count_q, count_d;
  logic          advance;
  logic          accept;
  logic [1:0]    n_res;
  gsle_out_t [MaxResults-1:0] res;

  assign advance    = in_valid_q && room_i;
  assign in_stall_o = in_valid_q && !room_i;
  assign accept     = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (accept) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_q <= in_data_i;
    end
  end

  // One byte of the scan: skip, held-lead pairing, fresh byte, chunk close.
  always_comb begin
    logic [7:0] b;
    logic       last;
    logic [7:0] h;
    logic       do_held;
    logic       do_fresh;
    b            = in_q.in_byte;
    last         = in_q.chunk_end;
    h            = held_q;
    do_held      = 1'b0;
    do_fresh     = 1'b0;
    phase_d      = phase_q;
    held_d       = held_q;
    held_valid_d = held_valid_q;
    count_d      = count_q;
    n_res        = 2'd0;
    res          = '0;

    if (phase_q == PhSkip) begin
      if (held_valid_q) begin
        held_valid_d = 1'b0;
        if (!((h == ChrCr && b == ChrLf) || (h == ChrA1 && b == ChrA1))) begin
          phase_d = PhCopy;
          if (!has_room(count_d, max_bytes_i) || h == ChrCr) begin
            res[n_res]   = '{out_byte: 8'd0, label_end: 1'b1, label_length: count_d};
            n_res        = n_res + 2'd1;
            phase_d      = PhDone;
            held_valid_d = 1'b0;
          end else begin
            held_valid_d = 1'b1;
            do_held      = 1'b1;
          end
        end
      end else if (b == ChrLf || b == ChrSpace || b == ChrTab) begin
        phase_d = PhSkip;
      end else if ((b == ChrCr || b == ChrA1) && !last) begin
        held_d       = b;
        held_valid_d = 1'b1;
      end else begin
        phase_d  = PhCopy;
        do_fresh = 1'b1;
      end
    end else if (phase_q == PhCopy) begin
      if (held_valid_q) begin
        do_held = 1'b1;
      end else begin
        do_fresh = 1'b1;
      end
    end

    if (do_held) begin
      held_valid_d = 1'b0;
      res[n_res]   = '{out_byte: h, label_end: 1'b0, label_length: 8'd0};
      n_res        = n_res + 2'd1;
      count_d      = count_d + 8'd1;
      if (b >= TrailMin) begin
        res[n_res] = '{out_byte: b, label_end: 1'b0, label_length: 8'd0};
        n_res      = n_res + 2'd1;
        count_d    = count_d + 8'd1;
        if (is_end_punct(h, b) || !has_room(count_d, max_bytes_i)) begin
          res[n_res] = '{out_byte: 8'd0, label_end: 1'b1, label_length: count_d};
          n_res      = n_res + 2'd1;
          phase_d    = PhDone;
        end
      end else if (!has_room(count_d, max_bytes_i)) begin
        res[n_res] = '{out_byte: 8'd0, label_end: 1'b1, label_length: count_d};
        n_res      = n_res + 2'd1;
        phase_d    = PhDone;
      end else begin
        do_fresh = 1'b1;
      end
    end

    if (do_fresh) begin
      if (!has_room(count_d, max_bytes_i) || b == ChrCr || b == ChrLf) begin
        res[n_res]   = '{out_byte: 8'd0, label_end: 1'b1, label_length: count_d};
        n_res        = n_res + 2'd1;
        phase_d      = PhDone;
        held_valid_d = 1'b0;
      end else if (b >= LeadMin && !last) begin
        held_d       = b;
        held_valid_d = 1'b1;
      end else begin
        res[n_res] = '{out_byte: b, label_end: 1'b0, label_length: 8'd0};
        n_res      = n_res + 2'd1;
        count_d    = count_d + 8'd1;
        if (!has_room(count_d, max_bytes_i)) begin
          res[n_res]   = '{out_byte: 8'd0, label_end: 1'b1, label_length: count_d};
          n_res        = n_res + 2'd1;
          phase_d      = PhDone;
          held_valid_d = 1'b0;
        end
      end
    end

    if (last) begin
      if (phase_d != PhDone) begin
        res[n_res] = '{out_byte: 8'd0, label_end: 1'b1, label_length: count_d};
        n_res      = n_res + 2'd1;
      end
      phase_d      = PhSkip;
      held_d       = 8'd0;
      held_valid_d = 1'b0;
      count_d      = 8'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q      <= PhSkip;
      held_q       <= 8'd0;
      held_valid_q <= 1'b0;
      count_q      <= 8'd0;
    end else if (advance) begin
      phase_q      <= phase_d;
      held_q       <= held_d;
      held_valid_q <= held_valid_d;
      count_q      <= count_d;
    end
  end

  assign push_o.count = advance ? n_res : 2'd0;
  assign push_o.item  = res;

endmodule

// ===== sv/gsle_fifo.sv =====
// Result queue: takes up to three results per cycle, gives one per cycle while not stalled.
// Depends on gsle_pkg.
module gsle_fifo import gsle_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  gsle_push_t push_i,
  output logic       room_o,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output gsle_out_t  out_data_o
);

  gsle_out_t               mem_q [FifoDepth];
  logic [FifoPtrW-1:0]     wr_ptr_q, wr_ptr_d;
  logic [FifoPtrW-1:0]     rd_ptr_q, rd_ptr_d;
  logic [FifoCntW-1:0]     cnt_q, cnt_d;
  logic                    pop;

  assign out_valid_o = (cnt_q != '0);
  assign out_data_o  = mem_q[rd_ptr_q];
  assign pop         = out_valid_o && !out_stall_i;
  assign room_o      = (cnt_q <= FifoCntW'(FifoDepth - MaxResults));

  always_comb begin
    wr_ptr_d = wr_ptr_q + FifoPtrW'(push_i.count);
    rd_ptr_d = rd_ptr_q + FifoPtrW'(pop);
    cnt_d    = cnt_q + FifoCntW'(push_i.count) - FifoCntW'(pop);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      cnt_q    <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      cnt_q    <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int k = 0; k < MaxResults; k++) begin
      if (k < int'(push_i.count)) begin
        mem_q[FifoPtrW'(wr_ptr_q + FifoPtrW'(k))] <= push_i.item[k];
      end
    end
  end

endmodule

// ===== sv/gbk_sentence_label_extract.sv =====
// Top level of the GBK sentence label extractor.
// Holds the configuration register and connects gsle_core and gsle_fifo; uses gsle_pkg.
//
// Usage:
// The input channel carries one transaction per raw text byte, with chunk_end
// set on the last byte of a chunk. The output channel carries the label bytes
// one per transaction, followed by a single end transaction (label_end set,
// out_byte zero) that reports the label length. Bytes that arrive after the
// label has closed are dropped until chunk_end, which restarts the scan.
// A byte is registered at the input, the scan logic works on it from that
// register, and any results it yields are written into the result queue,
// whose head drives the output.
// Throughput: one input transaction per cycle while in_stall_o is low. One byte
// can cause up to three results, so the sustained rate is bounded by the output
// side: an eight-entry queue gives one result per cycle while out_stall_i is low.
// Stalls: the input stage holds its byte while the queue has fewer than three
// free entries; in_stall_o then stays high. A stalled output keeps its data.
// Reset clears the scan state, empties the queue and sets max_label_bytes to 32.
// The APB register max_label_bytes sits at byte address 0 and should be
// written only while the block is idle.
module gbk_sentence_label_extract import gsle_pkg::*; (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                in_valid_i,
  output logic                in_stall_o,
  input  gsle_in_t            in_data_i,
  output logic                out_valid_o,
  input  logic                out_stall_i,
  output gsle_out_t           out_data_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [ApbAddrW-1:0] paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  logic [7:0]  max_bytes_q;
  logic        room;
  gsle_push_t  push;
  logic        reg_write;

  // The port never waits, so every access completes in its access cycle.
  assign pready    = 1'b1;
  assign reg_write = psel && penable && pwrite && pready && (paddr == RegMaxLabelBytes);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_bytes_q <= MaxLabelReset;
    end else if (reg_write) begin
      max_bytes_q <= pwdata[7:0];
    end
  end

  // Reads of unmapped addresses return zero.
  assign prdata = (paddr == RegMaxLabelBytes) ? {24'd0, max_bytes_q} : 32'd0;

  gsle_core u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .max_bytes_i (max_bytes_q),
    .room_i      (room),
    .push_o      (push)
  );

  gsle_fifo u_fifo (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .room_o      (room),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== sv/gsle_checker.sv =====
// Port-level checks for the GBK sentence label extractor, bound to the top level.
// Depends on gsle_pkg.
module gsle_checker import gsle_pkg::*; (
  input logic      clk_i,
  input logic      rst_ni,
  input logic      out_valid_o,
  input logic      out_stall_i,
  input gsle_out_t out_data_o
);

  // The result queue is empty in the cycle after reset has been seen.
  a_reset_empty: assert property (@(posedge clk_i) !rst_ni |=> !out_valid_o)
    else $error("output valid after reset");

  a_out_hold_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o)
    else $error("output valid dropped while stalled");

  a_out_hold_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> $stable(out_data_o))
    else $error("output data changed while stalled");

  // End transactions carry no byte; byte transactions carry no length.
  a_item_shape: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> (out_data_o.label_end ? (out_data_o.out_byte == 8'd0)
                                          : (out_data_o.label_length == 8'd0)))
    else $error("malformed result transaction");

endmodule

bind gbk_sentence_label_extract gsle_checker u_gsle_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o)
);
